>>> hw/rtl/lrsa_pkg.sv
`default_nettype none
package lrsa_pkg;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] atom_id;
    logic        negative;
    logic        in_head;
    logic [4:0]  stat_index;
  } in_item_t;

  typedef struct packed {
    logic [31:0] stat_value;
    logic        index_error;
  } out_item_t;

  // per-atom table entry
  typedef struct packed {
    logic [31:0] occ_total;
    logic [31:0] occ_pos;
    logic [31:0] occ_neg;
    logic [31:0] occ_hnb;
    logic        seen_pos;
    logic        seen_neg;
  } atom_entry_t;

  localparam logic [1:0] OP_LITERAL  = 2'd0;
  localparam logic [1:0] OP_RULE_END = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;

  localparam int STAT_COUNT = 27;

  localparam int ST_NON_HORN      = 0;
  localparam int ST_NON_DUAL_HORN = 1;
  localparam int ST_MAX_CLAUSE    = 2;
  localparam int ST_MAX_POS       = 3;
  localparam int ST_MAX_NEG       = 4;
  localparam int ST_SEEN_POS      = 5;
  localparam int ST_SEEN_NEG      = 6;
  localparam int ST_MAX_POS_CONS  = 7;
  localparam int ST_MAX_POS_RULE  = 8;
  localparam int ST_OCC_CONS      = 9;
  localparam int ST_OCC_RULE      = 10;
  localparam int ST_MAX_OCC       = 11;
  localparam int ST_MAX_OCC_POS   = 12;
  localparam int ST_MAX_OCC_NEG   = 13;
  localparam int ST_MAX_RULE_SIZE = 14;
  localparam int ST_MAX_HEAD_NB   = 15;
  localparam int ST_MAX_HEAD      = 16;
  localparam int ST_MAX_BODY      = 17;
  localparam int ST_MAX_NEG_BODY  = 18;
  localparam int ST_MAX_PB_CONS   = 19;
  localparam int ST_MAX_NB_CONS   = 20;
  localparam int ST_HEAD_ATOMS    = 21;
  localparam int ST_PB_ATOMS      = 22;
  localparam int ST_NB_ATOMS      = 23;
  localparam int ST_MAX_OCC_HNB   = 24;
  localparam int ST_FACTS         = 25;
  localparam int ST_CONSTRAINTS   = 26;

endpackage
`default_nettype wire

>>> hw/rtl/lrsa_in_if.sv
`default_nettype none
interface lrsa_in_if;
  import lrsa_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lrsa_out_if.sv
`default_nettype none
interface lrsa_out_if;
  import lrsa_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lrsa_ram.sv
`default_nettype none
module lrsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/logic_rule_statistics_accumulator.sv
// Gathers statistics over a logic program streamed as literals, rule ends and
// statistic reads. After reset the per-atom table is cleared one entry a cycle
// with in_ch.ready low. After that one item is taken every cycle unless a read
// result waits: the per-atom table is a single-port-write RAM read whenever an
// item is taken and, for a literal, written back the next cycle, with forwarding
// of the last write, so consecutive literals on the same atom do not stall. A
// read's result goes through the stage-1 and output registers to out_ch. After
// the clear, in_ch.ready drops only while a read waits for a full output register.
`default_nettype none
module logic_rule_statistics_accumulator #(
  parameter int ATOM_COUNT   = 4096,
  parameter int RULE_LEN_MAX = 1024
) (
  input wire logic   clk,
  input wire logic   rst_n,
  lrsa_in_if.sink    in_ch,
  lrsa_out_if.source out_ch
);
  import lrsa_pkg::*;

  localparam int AW = (ATOM_COUNT > 1) ? $clog2(ATOM_COUNT) : 1;
  localparam int RW = $clog2(RULE_LEN_MAX + 1);
  localparam int EW = $bits(atom_entry_t);

  logic          clr_done_r, clr_done_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;

  logic          s1_valid_r, s1_valid_nxt;
  in_item_t      s1_item_r;
  logic [AW-1:0] s1_addr_r;
  logic          s1_inr_r;

  logic          fwd_valid_r;
  logic [AW-1:0] fwd_addr_r;
  atom_entry_t   fwd_data_r;

  logic [RW-1:0] pb_r, nb_r, ph_r, nh_r, pb_nxt, nb_nxt, ph_nxt, nh_nxt;
  logic          head_seen_r, head_seen_nxt;
  logic [31:0]   stat_r [STAT_COUNT];
  logic [31:0]   stat_nxt [STAT_COUNT];

  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  logic          accept, adv, fire, drop;
  logic [AW+11:0] in_addr_ext;
  logic [AW-1:0] in_addr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  atom_entry_t   ram_wdata, ram_rdata, cur, upd;
  logic [EW-1:0] ram_rdata_raw;
  logic [31:0]   pb, nb, ph, nh, h, b, neg, pos;

  function automatic logic [31:0] max32(input logic [31:0] a, input logic [31:0] v);
    max32 = (a < v) ? v : a;
  endfunction

  assign in_addr_ext = {{AW{1'b0}}, in_ch.data.atom_id};
  assign in_addr     = in_addr_ext[AW-1:0];

  assign adv    = !(s1_valid_r && s1_item_r.operation == OP_READ && out_valid_r && !out_ch.ready);
  assign fire   = s1_valid_r && adv;
  assign in_ch.ready = clr_done_r && (!s1_valid_r || adv);
  assign accept = in_ch.valid && in_ch.ready;

  assign ram_rdata = atom_entry_t'(ram_rdata_raw);
  // forward the write that landed on the same edge as this item's read
  assign cur = (fwd_valid_r && fwd_addr_r == s1_addr_r) ? fwd_data_r : ram_rdata;

  assign drop = s1_item_r.in_head && !head_seen_r && s1_item_r.atom_id == 12'd1;

  assign pb  = 32'(pb_r);
  assign nb  = 32'(nb_r);
  assign ph  = 32'(ph_r);
  assign nh  = 32'(nh_r);
  assign h   = ph + nh;
  assign b   = pb + nb;
  assign neg = nb + nh;
  assign pos = pb + ph;

  always_comb begin
    upd          = cur;
    upd.occ_total = cur.occ_total + 32'd1;
    if (s1_item_r.negative) begin
      upd.occ_neg  = cur.occ_neg + 32'd1;
      upd.seen_neg = 1'b1;
    end else begin
      upd.occ_pos  = cur.occ_pos + 32'd1;
      upd.seen_pos = 1'b1;
    end
    if (s1_item_r.in_head || s1_item_r.negative) begin
      upd.occ_hnb = cur.occ_hnb + 32'd1;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = s1_addr_r;
    ram_wdata = upd;
    if (!clr_done_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (fire && s1_item_r.operation == OP_LITERAL && !drop && s1_inr_r) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    pb_nxt        = pb_r;
    nb_nxt        = nb_r;
    ph_nxt        = ph_r;
    nh_nxt        = nh_r;
    head_seen_nxt = head_seen_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;

    if (fire) begin
      case (s1_item_r.operation)
        OP_LITERAL: begin
          if (s1_item_r.in_head && !head_seen_r) begin
            head_seen_nxt = 1'b1;
          end
          if (!drop) begin
            if (s1_item_r.in_head) begin
              if (s1_item_r.negative) begin
                if (nh_r < RW'(RULE_LEN_MAX)) nh_nxt = nh_r + 1'b1;
              end else begin
                if (ph_r < RW'(RULE_LEN_MAX)) ph_nxt = ph_r + 1'b1;
              end
            end else begin
              if (s1_item_r.negative) begin
                if (nb_r < RW'(RULE_LEN_MAX)) nb_nxt = nb_r + 1'b1;
              end else begin
                if (pb_r < RW'(RULE_LEN_MAX)) pb_nxt = pb_r + 1'b1;
              end
            end
            if (s1_inr_r) begin
              stat_nxt[ST_MAX_OCC] = max32(stat_r[ST_MAX_OCC], upd.occ_total);
              if (s1_item_r.negative) begin
                stat_nxt[ST_MAX_OCC_NEG] = max32(stat_r[ST_MAX_OCC_NEG], upd.occ_neg);
                if (!cur.seen_neg) stat_nxt[ST_SEEN_NEG] = stat_r[ST_SEEN_NEG] + 32'd1;
              end else begin
                stat_nxt[ST_MAX_OCC_POS] = max32(stat_r[ST_MAX_OCC_POS], upd.occ_pos);
                if (!cur.seen_pos) stat_nxt[ST_SEEN_POS] = stat_r[ST_SEEN_POS] + 32'd1;
              end
              if (s1_item_r.in_head || s1_item_r.negative) begin
                stat_nxt[ST_MAX_OCC_HNB] = max32(stat_r[ST_MAX_OCC_HNB], upd.occ_hnb);
              end
            end
          end
        end
        OP_RULE_END: begin
          stat_nxt[ST_HEAD_ATOMS] = stat_r[ST_HEAD_ATOMS] + h;
          stat_nxt[ST_PB_ATOMS]   = stat_r[ST_PB_ATOMS] + pb;
          stat_nxt[ST_NB_ATOMS]   = stat_r[ST_NB_ATOMS] + nb;
          if (b == 32'd0) stat_nxt[ST_FACTS] = stat_r[ST_FACTS] + 32'd1;
          stat_nxt[ST_MAX_HEAD_NB]  = max32(stat_r[ST_MAX_HEAD_NB], h + nb);
          stat_nxt[ST_MAX_NEG_BODY] = max32(stat_r[ST_MAX_NEG_BODY], nb);
          stat_nxt[ST_MAX_HEAD]     = max32(stat_r[ST_MAX_HEAD], h);
          if (h == 32'd0) begin
            stat_nxt[ST_CONSTRAINTS]  = stat_r[ST_CONSTRAINTS] + 32'd1;
            stat_nxt[ST_OCC_CONS]     = stat_r[ST_OCC_CONS] + b;
            stat_nxt[ST_MAX_POS_CONS] = max32(stat_r[ST_MAX_POS_CONS], pos);
            stat_nxt[ST_MAX_PB_CONS]  = max32(stat_r[ST_MAX_PB_CONS], pb);
            stat_nxt[ST_MAX_NB_CONS]  = max32(stat_r[ST_MAX_NB_CONS], nb);
          end else begin
            stat_nxt[ST_MAX_RULE_SIZE] = max32(stat_r[ST_MAX_RULE_SIZE], h + b);
            stat_nxt[ST_OCC_RULE]      = stat_r[ST_OCC_RULE] + h + b;
            stat_nxt[ST_MAX_POS_RULE]  = max32(stat_r[ST_MAX_POS_RULE], pos);
            stat_nxt[ST_MAX_BODY]      = max32(stat_r[ST_MAX_BODY], b);
          end
          if (b != 32'd0 && !((h == 32'd0 && neg <= 32'd1) || (h == 32'd1 && neg == 32'd0))) begin
            stat_nxt[ST_NON_HORN] = stat_r[ST_NON_HORN] + 32'd1;
          end
          if (b != 32'd0 && pb > nh + 32'd1) begin
            stat_nxt[ST_NON_DUAL_HORN] = stat_r[ST_NON_DUAL_HORN] + 32'd1;
          end
          stat_nxt[ST_MAX_CLAUSE] = max32(stat_r[ST_MAX_CLAUSE], b + h);
          stat_nxt[ST_MAX_POS]    = max32(stat_r[ST_MAX_POS], pos);
          stat_nxt[ST_MAX_NEG]    = max32(stat_r[ST_MAX_NEG], neg);
          pb_nxt        = '0;
          nb_nxt        = '0;
          ph_nxt        = '0;
          nh_nxt        = '0;
          head_seen_nxt = 1'b0;
        end
        OP_READ: begin
          out_valid_nxt = 1'b1;
          if (s1_item_r.stat_index < 5'(STAT_COUNT)) begin
            out_data_nxt.stat_value  = stat_r[s1_item_r.stat_index];
            out_data_nxt.index_error = 1'b0;
          end else begin
            out_data_nxt.stat_value  = '0;
            out_data_nxt.index_error = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    clr_done_nxt = clr_done_r;
    if (!clr_done_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(ATOM_COUNT - 1)) clr_done_nxt = 1'b1;
    end
    s1_valid_nxt = accept ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  end

  lrsa_ram #(.WIDTH(EW), .DEPTH(ATOM_COUNT)) u_atom_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (EW'(ram_wdata)),
    .re    (accept),
    .raddr (in_addr),
    .rdata (ram_rdata_raw)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_done_r  <= 1'b0;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      pb_r        <= '0;
      nb_r        <= '0;
      ph_r        <= '0;
      nh_r        <= '0;
      head_seen_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < STAT_COUNT; i++) stat_r[i] <= '0;
    end else begin
      clr_done_r  <= clr_done_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      s1_valid_r  <= s1_valid_nxt;
      fwd_valid_r <= ram_we;
      pb_r        <= pb_nxt;
      nb_r        <= nb_nxt;
      ph_r        <= ph_nxt;
      nh_r        <= nh_nxt;
      head_seen_r <= head_seen_nxt;
      out_valid_r <= out_valid_nxt;
      stat_r      <= stat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= ram_waddr;
    fwd_data_r <= ram_wdata;
    out_data_r <= out_data_nxt;
    if (accept) begin
      s1_item_r <= in_ch.data;
      s1_addr_r <= in_addr;
      s1_inr_r  <= 32'(in_ch.data.atom_id) < 32'(ATOM_COUNT);
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_done_r |-> !accept) else $error("item taken during table clear");

  a_read_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_item_r.operation == OP_READ) |=> out_valid_r)
    else $error("read result lost");

  a_stall_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |-> (s1_item_r.operation == OP_READ && out_valid_r))
    else $error("pipeline stalled on a non-read item");

endmodule
`default_nettype wire
